// ===== src/srts_pkg.sv =====
package srts_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 3;

    localparam logic [31:0] CUTOFF_TICK = 32'd20000;

    // loop modes
    localparam logic [2:0] MODE_PERIOD_TICK = 3'd1;
    localparam logic [2:0] MODE_CUTOFF = 3'd2;
    localparam logic [2:0] MODE_STREAM = 3'd4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PACKET_KEY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_MODE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_FOREVER = 3'd4;

    // item functions
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic        func;
        logic [9:0]  entry_index;
        logic [31:0] entry_due;
        logic [31:0] entry_rate;
    } req_t;

    typedef struct packed {
        logic [31:0] out_key;
        logic [31:0] payload;
        logic        refill_request;
    } pkt_t;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] rate;
    } entry_t;

endpackage

// ===== src/srts_table.sv =====
module srts_table
    import srts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int AW = $clog2(DEFAULT_TABLE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/scheduled_rate_table_sequencer.sv =====
// scheduled rate table sequencer
//
// request channel (req_valid / req_stall / req_data): a load beat writes one
// (due, rate) entry into the schedule table; a tick beat advances the tick
// counter and normally produces one packet beat on the packet channel
// (pkt_valid / pkt_stall / pkt_data) carrying the key and the current rate.
// configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) and must be
// written only while the block is idle; the block itself does not enforce this.
//
// a tick beat is read from the table into the compare stage, then its
// packet is registered in the output register. throughput: a tick holds the
// request channel while in the compare stage, since the next tick's table
// address depends on this tick's due compare; loads run at one per cycle
// while no tick is there. ticks stopped by the run limit or the mode 2 cutoff
// do not stall and give no packet. reset sets the tick counter to all ones
// and clears the position, period sums, held rate and pipeline; the table
// content is undefined until loaded.
// a stalled packet stays in the output register; one further tick may be
// accepted and waits in the compare stage until the output register frees.
module scheduled_rate_table_sequencer
    import srts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req_data,
    output logic                   pkt_valid,
    input  logic                   pkt_stall,
    output pkt_t                   pkt_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // configuration registers
    logic [31:0]      packet_key_reg;
    logic [2:0]       loop_mode_reg;
    logic [CNT_W-1:0] entry_count_reg;
    logic [31:0]      run_limit_reg;
    logic             run_forever_reg;

    // sequencer state
    logic [31:0]      tick_now_reg;
    logic [CNT_W-1:0] entry_pos_reg;
    logic [31:0]      period_sum_reg;
    logic [31:0]      loop_period_reg;
    logic [31:0]      held_rate_reg;

    // compare stage and output register
    logic             s2_valid_reg;
    logic             pkt_valid_reg;
    pkt_t             pkt_data_reg;

    // table port
    entry_t           rd_entry;
    logic             tbl_wr_en;
    logic [AW-1:0]    tbl_wr_addr;
    entry_t           tbl_wr_data;
    logic             tbl_rd_en;
    logic [AW-1:0]    tbl_rd_addr;

    // accept side decode
    logic             req_acc;
    logic             tick_acc;
    logic [31:0]      load_idx;
    logic [31:0]      cnt_clamped;
    logic [2:0]       mode_clamped;

    // tick front end, computed from settled state
    logic [31:0]      tick_inc;
    logic             run_stop;
    logic             cut_stop;
    logic             looping;
    logic             wrap;
    logic [31:0]      period_next;
    logic [CNT_W-1:0] pos_wrapped;
    logic [CNT_W-1:0] pos_eff;
    logic             tick_emit;

    // compare stage
    logic             s2_fire;
    logic [31:0]      due_cmp;
    logic             due_match;
    logic [CNT_W-1:0] pos_inc;
    logic             stream_wrap;
    pkt_t             pkt_next;

    // a tick in the compare stage owns entry_pos until it retires
    assign req_stall = s2_valid_reg;
    assign req_acc   = req_valid && !req_stall;
    assign tick_acc  = req_acc && (req_data.func == FUNC_TICK);

    // load path: indexes beyond the table are dropped
    assign load_idx    = 32'(req_data.entry_index);
    assign tbl_wr_en   = req_acc && (req_data.func == FUNC_LOAD)
                         && (load_idx < 32'(TABLE_DEPTH));
    assign tbl_wr_addr = load_idx[AW-1:0];
    assign tbl_wr_data = '{due: req_data.entry_due, rate: req_data.entry_rate};

    // tick front end: counter, stop checks, loop wrap
    assign tick_inc  = tick_now_reg + 32'd1;
    assign run_stop  = !run_forever_reg && (tick_inc >= run_limit_reg);
    assign cut_stop  = (loop_mode_reg == MODE_CUTOFF) && (tick_inc >= CUTOFF_TICK);
    assign looping   = loop_mode_reg < MODE_STREAM;
    assign wrap      = looping && (entry_pos_reg >= entry_count_reg);
    assign tick_emit = tick_acc && !run_stop && !cut_stop;

    // the loop period is latched on a wrap only while the period sum is still zero
    always_comb
    begin
        period_next = loop_period_reg;
        if (period_sum_reg == 32'd0)
        begin
            period_next = (loop_mode_reg == MODE_PERIOD_TICK) ? tick_inc
                                                              : 32'(entry_pos_reg);
        end
    end

    assign pos_wrapped = wrap ? '0 : entry_pos_reg;
    // position left at the table end after a mode change goes back to zero
    assign pos_eff     = (pos_wrapped >= DEPTH_CNT) ? '0 : pos_wrapped;

    assign tbl_rd_en   = tick_emit;
    assign tbl_rd_addr = pos_eff[AW-1:0];

    srts_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (rd_entry)
    );

    // compare stage retires when the output register is free next cycle
    assign s2_fire   = s2_valid_reg && !(pkt_valid_reg && pkt_stall);
    assign due_cmp   = rd_entry.due + (looping ? period_sum_reg : 32'd0);
    assign due_match = due_cmp == tick_now_reg;
    assign pos_inc   = entry_pos_reg + CNT_W'(1);
    assign stream_wrap = !looping && (pos_inc >= DEPTH_CNT);

    always_comb
    begin
        pkt_next.out_key        = packet_key_reg;
        pkt_next.refill_request = due_match && stream_wrap;
        if (due_match)
        begin
            pkt_next.payload = rd_entry.rate;
        end
        else if (looping)
        begin
            pkt_next.payload = held_rate_reg;
        end
        else
        begin
            pkt_next.payload = 32'd0;
        end
    end

    // configuration decode, with clamping of mode and entry count
    assign mode_clamped = (cfg_wdata[2:0] > MODE_STREAM) ? MODE_STREAM : cfg_wdata[2:0];
    assign cnt_clamped  = (32'(cfg_wdata[10:0]) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                                    : 32'(cfg_wdata[10:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_key_reg  <= '0;
            loop_mode_reg   <= '0;
            entry_count_reg <= '0;
            run_limit_reg   <= '0;
            run_forever_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PACKET_KEY:  packet_key_reg  <= cfg_wdata[31:0];
                REG_LOOP_MODE:   loop_mode_reg   <= mode_clamped;
                REG_ENTRY_COUNT: entry_count_reg <= cnt_clamped[CNT_W-1:0];
                REG_RUN_LIMIT:   run_limit_reg   <= cfg_wdata[31:0];
                REG_RUN_FOREVER: run_forever_reg <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // sequencer state: front end updates at accept, compare stage at retire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg    <= '1;
            entry_pos_reg   <= '0;
            period_sum_reg  <= '0;
            loop_period_reg <= '0;
            held_rate_reg   <= '0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            if (tick_acc && !run_stop)
            begin
                tick_now_reg <= tick_inc;
            end
            if (tick_emit)
            begin
                entry_pos_reg <= pos_eff;
                if (wrap)
                begin
                    loop_period_reg <= period_next;
                    period_sum_reg  <= period_sum_reg + period_next;
                end
                s2_valid_reg <= 1'b1;
            end
            else if (s2_fire)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_fire && due_match)
            begin
                entry_pos_reg <= stream_wrap ? '0 : pos_inc;
                // a zero rate due at tick zero leaves the held rate alone
                if (!(due_cmp == 32'd0 && rd_entry.rate == 32'd0))
                begin
                    held_rate_reg <= rd_entry.rate;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
        end
        else if (s2_fire)
        begin
            pkt_valid_reg <= 1'b1;
        end
        else if (!pkt_stall)
        begin
            pkt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            pkt_data_reg <= pkt_next;
        end
    end

    assign pkt_valid = pkt_valid_reg;
    assign pkt_data  = pkt_data_reg;

endmodule

// ===== src/srts_checker.sv =====
module srts_checker
    import srts_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_stall,
    input req_t                   req_data,
    input logic                   pkt_valid,
    input logic                   pkt_stall,
    input pkt_t                   pkt_data,
    input logic                   cfg_we,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic tick_beat;

    assign tick_beat = req_valid && !req_stall && (req_data.func == FUNC_TICK);

    // a stalled packet beat holds
    a_pkt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt_data))
        else $error("packet beat changed under stall");

    // the request channel only blocks right after a tick beat
    a_tick_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(req_stall) |-> $past(tick_beat))
        else $error("request channel blocked without a tick beat");

    // a packet beat rises only from a tick beat, through the compare stage and the output register
    a_pkt_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pkt_valid) |-> $past(tick_beat, 2))
        else $error("packet beat without a tick beat");

    // a refill packet never follows a load beat directly
    a_refill_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pkt_valid) && pkt_data.refill_request |-> $past(req_stall, 1))
        else $error("refill packet without a compare stage");

endmodule

bind scheduled_rate_table_sequencer srts_checker u_srts_checker (.*);
